// ----- src/dbf_pkg.sv -----
// ----------------------------------------------------------------------------
// dbf_pkg: shared types and constants of the detection box filter
// Holds the register map, field widths and the structs that travel between
// the configuration block, the evaluation logic and the top level.
// ----------------------------------------------------------------------------
package dbf_pkg;

   // Proposal budget per frame and the width of the counter that tracks it.
   localparam int MAX_PROPOSALS = 128;
   localparam int PROP_IDX_W    = $clog2(MAX_PROPOSALS + 1);

   // Number of classes that the class mask covers.
   localparam int NUM_CLASSES = 21;
   localparam int CLASS_W     = 5;

   // Field widths.
   localparam int COORD_W = 18;
   localparam int SIZE_W  = 13;
   localparam int PIX_W   = SIZE_W + 1;
   localparam int CONF_W  = 16;
   localparam int LABEL_W = 8;
   localparam int ID_W    = 7;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 21;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_CUT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_MARGIN = 3'd5;

   // Register reset values.
   localparam logic [SIZE_W-1:0]      RST_FRAME_WIDTH   = 13'd1920;
   localparam logic [SIZE_W-1:0]      RST_FRAME_HEIGHT  = 13'd1080;
   localparam logic [CONF_W-1:0]      RST_CONF_THRESH   = 16'd13107;
   localparam logic [NUM_CLASSES-1:0] RST_CLASS_MASK    = 21'd32960;
   localparam logic [SIZE_W-1:0]      RST_TOP_CUT       = 13'd108;
   localparam logic [SIZE_W-1:0]      RST_BOTTOM_MARGIN = 13'd10;

   typedef struct packed {
      logic [SIZE_W-1:0]      frame_width;
      logic [SIZE_W-1:0]      frame_height;
      logic [CONF_W-1:0]      confidence_threshold;
      logic [NUM_CLASSES-1:0] tracked_class_mask;
      logic [SIZE_W-1:0]      top_cut_rows;
      logic [SIZE_W-1:0]      bottom_margin_rows;
   } dbf_cfg_type;

   typedef struct packed {
      logic                      frame_start;
      logic                      end_marker;
      logic [LABEL_W-1:0]        class_label;
      logic [CONF_W-1:0]         confidence;
      logic signed [COORD_W-1:0] left_norm;
      logic signed [COORD_W-1:0] top_norm;
      logic signed [COORD_W-1:0] right_norm;
      logic signed [COORD_W-1:0] bottom_norm;
   } dbf_item_type;

   typedef struct packed {
      logic [ID_W-1:0]    object_id;
      logic [CLASS_W-1:0] class_index;
      logic [CONF_W-1:0]  object_confidence;
      logic [SIZE_W-1:0]  rect_x;
      logic [SIZE_W-1:0]  rect_y;
      logic [SIZE_W-1:0]  rect_width;
      logic [SIZE_W-1:0]  rect_height;
   } dbf_result_type;

   typedef struct packed {
      logic [ID_W-1:0]       accepted_count;
      logic                  list_ended;
      logic [PROP_IDX_W-1:0] proposal_index;
   } dbf_state_type;

endpackage

// ----- src/dbf_if.sv -----
// ----------------------------------------------------------------------------
// dbf_req_if / dbf_rsp_if: proposal and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface dbf_req_if;
   logic              valid;
   logic              ready;
   logic              frame_start;
   logic              end_marker;
   logic [7:0]        class_label;
   logic [15:0]       confidence;
   logic signed [17:0] left_norm;
   logic signed [17:0] top_norm;
   logic signed [17:0] right_norm;
   logic signed [17:0] bottom_norm;

   modport source (
      output valid, frame_start, end_marker, class_label, confidence,
             left_norm, top_norm, right_norm, bottom_norm,
      input  ready
   );
   modport sink (
      input  valid, frame_start, end_marker, class_label, confidence,
             left_norm, top_norm, right_norm, bottom_norm,
      output ready
   );
endinterface

interface dbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  object_id;
   logic [4:0]  class_index;
   logic [15:0] object_confidence;
   logic [12:0] rect_x;
   logic [12:0] rect_y;
   logic [12:0] rect_width;
   logic [12:0] rect_height;

   modport source (
      output valid, object_id, class_index, object_confidence,
             rect_x, rect_y, rect_width, rect_height,
      input  ready
   );
   modport sink (
      input  valid, object_id, class_index, object_confidence,
             rect_x, rect_y, rect_width, rect_height,
      output ready
   );
endinterface

// ----- src/detection_box_filter.sv -----
// ----------------------------------------------------------------------------
// detection_box_filter: detector proposal filter
// Turns a stream of normalized detector proposals into pixel rectangles of
// the objects that pass the confidence, class and position filters.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one proposal per transfer; rsp_chan carries one result
//   per kept proposal, and dropped proposals give no transfer at all.
//   The csr_ port writes the six configuration registers; write them only
//   while no proposal is in flight.
// Path: a transferred proposal is registered in the input register, is
//   evaluated from there and its result, if kept, is registered in the
//   output register, from which rsp_chan offers it.
// Throughput: one proposal per cycle; the input register and the output
//   register both keep moving while rsp_chan.ready is high.
// Stall: when the receiver holds rsp_chan.ready low with a result waiting,
//   the input register still takes one more proposal if it is empty, then
//   req_chan.ready drops until the output register is freed.
// Reset: synchronous; clears both pipeline stages, the object counter, the
//   ended flag and the proposal count, and loads the register defaults.
// ----------------------------------------------------------------------------
module detection_box_filter (
   input  logic                           clock,
   input  logic                           reset,
   dbf_req_if.sink                        req_chan,
   dbf_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [dbf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dbf_pkg::*;

   dbf_cfg_type    cfg;
   dbf_item_type   req_item;
   dbf_item_type   s1_item_ff;
   logic           s1_valid_ff, s1_valid_in;
   dbf_state_type  state_ff, state_next;
   logic           rsp_valid_ff, rsp_valid_in;
   dbf_result_type rsp_data_ff, eval_result;
   logic           keep;
   logic           advance;
   logic           req_xfer;

   dbf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg      (cfg)
   );

   // Gather the proposal fields.
   always_comb begin
      req_item.frame_start = req_chan.frame_start;
      req_item.end_marker  = req_chan.end_marker;
      req_item.class_label = req_chan.class_label;
      req_item.confidence  = req_chan.confidence;
      req_item.left_norm   = req_chan.left_norm;
      req_item.top_norm    = req_chan.top_norm;
      req_item.right_norm  = req_chan.right_norm;
      req_item.bottom_norm = req_chan.bottom_norm;
   end

   // The registered proposal moves on whenever the output register is free.
   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   dbf_eval u_eval (
      .item      (s1_item_ff),
      .cfg       (cfg),
      .state     (state_ff),
      .keep      (keep),
      .result    (eval_result),
      .state_next(state_next)
   );

   // Valid flags of the two stages.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = keep;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_item;
      end
      if (advance && keep) begin
         rsp_data_ff <= eval_result;
      end
   end

   // Result channel.
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.object_id         = rsp_data_ff.object_id;
   assign rsp_chan.class_index       = rsp_data_ff.class_index;
   assign rsp_chan.object_confidence = rsp_data_ff.object_confidence;
   assign rsp_chan.rect_x            = rsp_data_ff.rect_x;
   assign rsp_chan.rect_y            = rsp_data_ff.rect_y;
   assign rsp_chan.rect_width        = rsp_data_ff.rect_width;
   assign rsp_chan.rect_height       = rsp_data_ff.rect_height;

endmodule

// ----- src/dbf_csr.sv -----
// ----------------------------------------------------------------------------
// dbf_csr: configuration registers
// Write-only register file; each write updates the selected register.
// ----------------------------------------------------------------------------
module dbf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [dbf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output dbf_pkg::dbf_cfg_type          cfg
);
   import dbf_pkg::*;

   dbf_cfg_type cfg_ff;
   dbf_cfg_type cfg_in;

   // Select the register that a write targets; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   cfg_in.frame_width          = csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height         = csr_wdata[SIZE_W-1:0];
            CSR_CONF_THRESH:   cfg_in.confidence_threshold = csr_wdata[CONF_W-1:0];
            CSR_CLASS_MASK:    cfg_in.tracked_class_mask   = csr_wdata[NUM_CLASSES-1:0];
            CSR_TOP_CUT:       cfg_in.top_cut_rows         = csr_wdata[SIZE_W-1:0];
            CSR_BOTTOM_MARGIN: cfg_in.bottom_margin_rows   = csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width          <= RST_FRAME_WIDTH;
         cfg_ff.frame_height         <= RST_FRAME_HEIGHT;
         cfg_ff.confidence_threshold <= RST_CONF_THRESH;
         cfg_ff.tracked_class_mask   <= RST_CLASS_MASK;
         cfg_ff.top_cut_rows         <= RST_TOP_CUT;
         cfg_ff.bottom_margin_rows   <= RST_BOTTOM_MARGIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/dbf_scale.sv -----
// ----------------------------------------------------------------------------
// dbf_scale: coordinate scaling and clamping
// Multiplies a Q2.16 coordinate by a pixel size, truncates toward zero and
// clamps into the range zero to size minus one.
// ----------------------------------------------------------------------------
module dbf_scale (
   input  logic signed [dbf_pkg::COORD_W-1:0] coord,
   input  logic        [dbf_pkg::SIZE_W-1:0]  size,
   output logic signed [dbf_pkg::PIX_W-1:0]   pix
);
   import dbf_pkg::*;

   localparam int PROD_W = COORD_W + PIX_W;

   logic signed [PIX_W-1:0]  size_s;
   logic signed [PROD_W-1:0] prod;
   logic        [PIX_W-1:0]  whole;

   assign size_s = $signed({1'b0, size});
   assign prod   = PROD_W'(coord) * PROD_W'(size_s);

   // A negative product truncates to zero or less, which clamps to zero.
   assign whole = prod[PROD_W-1] ? '0 : prod[PIX_W+15:16];

   // Values at or past the size clamp to the last pixel; a zero size gives -1.
   assign pix = (whole >= PIX_W'({1'b0, size})) ? (size_s - PIX_W'(1))
                                                 : $signed(whole);

endmodule

// ----- src/dbf_eval.sv -----
// ----------------------------------------------------------------------------
// dbf_eval: proposal evaluation
// Decides whether a proposal is consumed and kept, forms its pixel rectangle
// and computes the frame state that follows it.
// ----------------------------------------------------------------------------
module dbf_eval (
   input  dbf_pkg::dbf_item_type   item,
   input  dbf_pkg::dbf_cfg_type    cfg,
   input  dbf_pkg::dbf_state_type  state,
   output logic                    keep,
   output dbf_pkg::dbf_result_type result,
   output dbf_pkg::dbf_state_type  state_next
);
   import dbf_pkg::*;

   dbf_state_type        eff;
   logic                 consumed;
   logic                 class_ok;
   logic                 box_ok;
   logic signed [PIX_W-1:0] xmin, ymin, xmax, ymax;
   logic signed [PIX_W:0]   bottom_limit;
   logic [PIX_W-1:0]        width_full, height_full;

   // A frame start clears the frame state before this proposal is looked at.
   assign eff = item.frame_start ? '0 : state;

   assign consumed = !eff.list_ended &&
                     (eff.proposal_index < PROP_IDX_W'(MAX_PROPOSALS));

   // Scale all four corners in parallel.
   dbf_scale u_left   (.coord(item.left_norm),   .size(cfg.frame_width),  .pix(xmin));
   dbf_scale u_top    (.coord(item.top_norm),    .size(cfg.frame_height), .pix(ymin));
   dbf_scale u_right  (.coord(item.right_norm),  .size(cfg.frame_width),  .pix(xmax));
   dbf_scale u_bottom (.coord(item.bottom_norm), .size(cfg.frame_height), .pix(ymax));

   // Class must be known and enabled in the mask.
   assign class_ok = (item.class_label < LABEL_W'(NUM_CLASSES)) &&
                     cfg.tracked_class_mask[item.class_label[CLASS_W-1:0]];

   // Box must be non-degenerate and lie between the top cut and bottom margin.
   assign bottom_limit = $signed({2'b00, cfg.frame_height}) -
                         $signed({2'b00, cfg.bottom_margin_rows});

   assign box_ok = (xmin < xmax) && (ymin < ymax) &&
                   (ymin >= $signed({1'b0, cfg.top_cut_rows})) &&
                   ($signed({ymax[PIX_W-1], ymax}) < bottom_limit);

   assign keep = consumed && !item.end_marker &&
                 (item.confidence >= cfg.confidence_threshold) &&
                 class_ok && box_ok;

   // Rectangle of a kept proposal.
   assign width_full  = PIX_W'(xmax - xmin + PIX_W'(1));
   assign height_full = PIX_W'(ymax - ymin + PIX_W'(1));

   always_comb begin
      result.object_id         = eff.accepted_count;
      result.class_index       = item.class_label[CLASS_W-1:0];
      result.object_confidence = item.confidence;
      result.rect_x            = xmin[SIZE_W-1:0];
      result.rect_y            = ymin[SIZE_W-1:0];
      result.rect_width        = width_full[SIZE_W-1:0];
      result.rect_height       = height_full[SIZE_W-1:0];
   end

   // Frame state after this proposal.
   always_comb begin
      state_next = eff;
      if (consumed) begin
         state_next.proposal_index = eff.proposal_index + PROP_IDX_W'(1);
         if (item.end_marker) begin
            state_next.list_ended = 1'b1;
         end
      end
      if (keep) begin
         state_next.accepted_count = eff.accepted_count + ID_W'(1);
      end
   end

endmodule

// ----- src/dbf_checker.sv -----
// ----------------------------------------------------------------------------
// dbf_checker: port-level checks of the detection box filter
// Watches the result channel and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module dbf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dbf_pkg::CLASS_W-1:0] class_index,
   input logic [dbf_pkg::SIZE_W-1:0]  rect_width,
   input logic [dbf_pkg::SIZE_W-1:0]  rect_height
);
   import dbf_pkg::*;

   // A pending result stays offered until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // Reset leaves no result pending.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Only known class indexes, below the class count, reach the output.
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (class_index < CLASS_W'(NUM_CLASSES)))
      else $error("class index out of range");

   // Kept boxes are never degenerate.
   a_box_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rect_width >= SIZE_W'(2)) && (rect_height >= SIZE_W'(2)))
      else $error("degenerate box on output");

endmodule

bind detection_box_filter dbf_checker u_dbf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .class_index(rsp_chan.class_index),
   .rect_width (rsp_chan.rect_width),
   .rect_height(rsp_chan.rect_height)
);

// ----- tb/sv/detection_box_filter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_box_filter_tb: self-checking bench for the detection box filter
// Streams detector proposals through the filter and checks every rectangle
// against a predictor kept in the bench. A short table of directed rows comes
// first, then phases of random frames under changing register settings, with
// bursty proposal traffic and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module detection_box_filter_tb;
   import dbf_pkg::*;

   localparam int DRAIN_CYCLES = 4;
   localparam int QUIET_LIMIT  = 3000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 125;

   localparam int Q_QUARTER = 16384;
   localparam int Q_HALF    = 32768;
   localparam int Q_MIN     = -131072;
   localparam int Q_MAX     = 131071;

   localparam int CLS_CHAIR  = 6;
   localparam int CLS_CAR    = 7;
   localparam int CLS_PERSON = 15;

   typedef enum logic [1:0] {WANT_MODEL, WANT_NONE, WANT_RECT} want_kind_type;
   typedef enum logic [1:0] {PROP_IGNORED, PROP_DROPPED, PROP_KEPT} proposal_fate_type;
   typedef enum logic [1:0] {TAKE_ALL, TAKE_MOST, TAKE_FEW, TAKE_EVERY_THIRD} sink_mode_type;

   typedef struct packed {
      dbf_item_type   item;
      want_kind_type  check;
      dbf_result_type want;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dbf_req_if proposal_chan ();
   dbf_rsp_if rect_chan ();

   detection_box_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (proposal_chan),
      .rsp_chan  (rect_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the registers and of the per-frame state.
   dbf_cfg_type    cfg_shadow;
   logic [ID_W-1:0] obj_count;
   bit             list_done;
   int             consumed;

   directed_row_type directed_rows[$];
   dbf_result_type expected_rects[$];
   int             mismatches = 0;
   int             live_items = 0;
   int             burst_left = 0;
   int             quiet_cycles = 0;
   bit             hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Appends one row to the directed table.
   function automatic void add_row(input directed_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Appends one rectangle to the list of results still to come.
   function automatic void queue_rect(input dbf_result_type rect);
      expected_rects.insert(expected_rects.size(), rect);
   endfunction

   // Pixel position of a Q2.16 coordinate: exact product, truncated toward
   // zero, then clamped to the frame.
   function automatic int to_pixel(input logic signed [COORD_W-1:0] coord, input int size);
      longint prod;
      int     pix;
      prod = longint'(coord) * longint'(size);
      if (prod < 0) begin
         pix = -int'((-prod) >> 16);
      end else begin
         pix = int'(prod >> 16);
      end
      if (pix < 0) pix = 0;
      if (pix >= size) pix = size - 1;
      return pix;
   endfunction

   // Runs one accepted proposal through the filter rules and updates the
   // frame state. The rectangle is valid only when the proposal is kept.
   function automatic proposal_fate_type filter_proposal(input dbf_item_type it,
                                                         output dbf_result_type rect);
      int fw, fh, top_cut, margin, xmin, ymin, xmax, ymax;
      rect    = '0;
      fw      = cfg_shadow.frame_width;
      fh      = cfg_shadow.frame_height;
      top_cut = cfg_shadow.top_cut_rows;
      margin  = cfg_shadow.bottom_margin_rows;
      if (it.frame_start) begin
         obj_count = '0;
         list_done = 1'b0;
         consumed  = 0;
      end
      if (list_done || consumed >= MAX_PROPOSALS) return PROP_IGNORED;
      consumed++;
      if (it.end_marker) begin
         list_done = 1'b1;
         return PROP_DROPPED;
      end
      if (it.confidence < cfg_shadow.confidence_threshold) return PROP_DROPPED;
      if (it.class_label >= NUM_CLASSES) return PROP_DROPPED;
      if (!cfg_shadow.tracked_class_mask[it.class_label[CLASS_W-1:0]]) return PROP_DROPPED;
      xmin = to_pixel(it.left_norm, fw);
      ymin = to_pixel(it.top_norm, fh);
      xmax = to_pixel(it.right_norm, fw);
      ymax = to_pixel(it.bottom_norm, fh);
      if (xmin >= xmax || ymin >= ymax) return PROP_DROPPED;
      if (ymin < top_cut) return PROP_DROPPED;
      if (ymax >= fh - margin) return PROP_DROPPED;
      rect.object_id         = obj_count;
      rect.class_index       = it.class_label[CLASS_W-1:0];
      rect.object_confidence = it.confidence;
      rect.rect_x            = xmin[SIZE_W-1:0];
      rect.rect_y            = ymin[SIZE_W-1:0];
      rect.rect_width        = 13'(xmax - xmin + 1);
      rect.rect_height       = 13'(ymax - ymin + 1);
      obj_count++;
      return PROP_KEPT;
   endfunction

   function automatic dbf_item_type make_item(input bit fs, input bit em, input int label,
                                              input int conf, input int l, input int t,
                                              input int r, input int b);
      dbf_item_type it;
      it.frame_start = fs;
      it.end_marker  = em;
      it.class_label = 8'(label);
      it.confidence  = 16'(conf);
      it.left_norm   = 18'(l);
      it.top_norm    = 18'(t);
      it.right_norm  = 18'(r);
      it.bottom_norm = 18'(b);
      return it;
   endfunction

   function automatic dbf_result_type make_rect(input int id, input int cls, input int conf,
                                                input int x, input int y, input int w,
                                                input int h);
      dbf_result_type rect;
      rect = '{7'(id), 5'(cls), 16'(conf), 13'(x), 13'(y), 13'(w), 13'(h)};
      return rect;
   endfunction

   // A plausible proposal under the current settings: a tracked class, a
   // confidence that passes and an ordered box inside the frame. Unless it
   // is to be clean, some of its fields are thrown out of range.
   function automatic dbf_item_type random_proposal(input bit first, input bit clean);
      dbf_item_type it;
      int           cls, tries, lo, hi;
      cls = $urandom_range(0, NUM_CLASSES - 1);
      for (tries = 0; tries < 40 && !cfg_shadow.tracked_class_mask[cls]; tries++) begin
         cls = $urandom_range(0, NUM_CLASSES - 1);
      end
      it.frame_start = first;
      it.end_marker  = 1'b0;
      it.class_label = 8'(cls);
      it.confidence  = 16'($urandom_range(cfg_shadow.confidence_threshold, 16'hFFFF));
      lo = $urandom_range(0, 65000);
      hi = $urandom_range(lo + 1, 65535);
      it.left_norm  = 18'(lo);
      it.right_norm = 18'(hi);
      lo = $urandom_range(0, 65000);
      hi = $urandom_range(lo + 1, 65535);
      it.top_norm    = 18'(lo);
      it.bottom_norm = 18'(hi);
      if (!clean) begin
         if ($urandom_range(0, 9) == 0) it.class_label = 8'($urandom);
         if ($urandom_range(0, 9) == 0) it.confidence = 16'($urandom);
         if ($urandom_range(0, 9) == 0) it.left_norm = 18'($urandom);
         if ($urandom_range(0, 9) == 0) it.top_norm = 18'($urandom);
         if ($urandom_range(0, 9) == 0) it.right_norm = 18'($urandom);
         if ($urandom_range(0, 9) == 0) it.bottom_norm = 18'($urandom);
      end
      return it;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Offers one proposal, idling first when the current burst is used up.
   // After the transfer the expectation is queued, either from the predictor
   // or as typed into the directed table.
   task automatic send_proposal(input dbf_item_type it, input want_kind_type check,
                                input dbf_result_type want);
      dbf_result_type    model_rect;
      proposal_fate_type fate;
      int                gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            proposal_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      proposal_chan.valid       <= 1'b1;
      proposal_chan.frame_start <= it.frame_start;
      proposal_chan.end_marker  <= it.end_marker;
      proposal_chan.class_label <= it.class_label;
      proposal_chan.confidence  <= it.confidence;
      proposal_chan.left_norm   <= it.left_norm;
      proposal_chan.top_norm    <= it.top_norm;
      proposal_chan.right_norm  <= it.right_norm;
      proposal_chan.bottom_norm <= it.bottom_norm;
      do @(posedge clock); while (!proposal_chan.ready);
      fate = filter_proposal(it, model_rect);
      if (fate != PROP_IGNORED) live_items++;
      case (check)
         WANT_MODEL: if (fate == PROP_KEPT) queue_rect(model_rect);
         WANT_RECT:  queue_rect(want);
         default: ;
      endcase
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Stops the proposal stream, waits for the filter to drain and loads a
   // full set of registers.
   task automatic load_settings(input dbf_cfg_type settings);
      proposal_chan.valid <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(settings.frame_width));
      write_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(settings.frame_height));
      write_csr(CSR_CONF_THRESH, CSR_DATA_W'(settings.confidence_threshold));
      write_csr(CSR_CLASS_MASK, CSR_DATA_W'(settings.tracked_class_mask));
      write_csr(CSR_TOP_CUT, CSR_DATA_W'(settings.top_cut_rows));
      write_csr(CSR_BOTTOM_MARGIN, CSR_DATA_W'(settings.bottom_margin_rows));
      csr_we <= 1'b0;
      cfg_shadow = settings;
   endtask

   // Result checker: every rectangle transfer is matched against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : rect_checker
      dbf_result_type got, want;
      if (!reset && rect_chan.valid && rect_chan.ready) begin
         got = '{rect_chan.object_id, rect_chan.class_index, rect_chan.object_confidence,
                 rect_chan.rect_x, rect_chan.rect_y, rect_chan.rect_width,
                 rect_chan.rect_height};
         if (expected_rects.size() == 0) begin
            report_mismatch("unexpected rectangle, object_id", got.object_id, 0);
         end else begin
            want = expected_rects.pop_front();
            if (got.object_id !== want.object_id)
               report_mismatch("object_id", got.object_id, want.object_id);
            if (got.class_index !== want.class_index)
               report_mismatch("class_index", got.class_index, want.class_index);
            if (got.object_confidence !== want.object_confidence)
               report_mismatch("object_confidence", got.object_confidence,
                               want.object_confidence);
            if (got.rect_x !== want.rect_x)
               report_mismatch("rect_x", got.rect_x, want.rect_x);
            if (got.rect_y !== want.rect_y)
               report_mismatch("rect_y", got.rect_y, want.rect_y);
            if (got.rect_width !== want.rect_width)
               report_mismatch("rect_width", got.rect_width, want.rect_width);
            if (got.rect_height !== want.rect_height)
               report_mismatch("rect_height", got.rect_height, want.rect_height);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens on either channel for
   // too long.
   always @(posedge clock) begin
      if ((proposal_chan.valid && proposal_chan.ready) || (rect_chan.valid && rect_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("detection_box_filter_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: switches between stall patterns, and once holds off for a
   // long stretch when the stimulus asks for it.
   initial begin : rect_receiver
      sink_mode_type mode;
      int            mode_left, hold_left, tick;
      bit            take;
      rect_chan.ready <= 1'b0;
      mode      = TAKE_ALL;
      mode_left = 50;
      hold_left = 0;
      tick      = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         tick++;
         if (hold_left > 0) begin
            take = 1'b0;
            hold_left--;
         end else begin
            case (mode)
               TAKE_ALL:  take = 1'b1;
               TAKE_MOST: take = ($urandom_range(0, 3) != 0);
               TAKE_FEW:  take = ($urandom_range(0, 3) == 0);
               default:   take = (tick % 3 == 0);
            endcase
         end
         rect_chan.ready <= take;
      end
   end

   // Stimulus: reset, directed table, then random phases.
   initial begin : proposal_stimulus
      dbf_cfg_type      settings;
      dbf_item_type     it;
      int               phase, target, frame_kind, frame_len, k;
      bit               clean_frame;

      reset                     <= 1'b1;
      csr_we                    <= 1'b0;
      csr_index                 <= '0;
      csr_wdata                 <= '0;
      proposal_chan.valid       <= 1'b0;
      proposal_chan.frame_start <= 1'b0;
      proposal_chan.end_marker  <= 1'b0;
      proposal_chan.class_label <= '0;
      proposal_chan.confidence  <= '0;
      proposal_chan.left_norm   <= '0;
      proposal_chan.top_norm    <= '0;
      proposal_chan.right_norm  <= '0;
      proposal_chan.bottom_norm <= '0;

      cfg_shadow = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_CONF_THRESH, RST_CLASS_MASK,
                     RST_TOP_CUT, RST_BOTTOM_MARGIN};
      obj_count  = '0;
      list_done  = 1'b0;
      consumed   = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed rows under the reset settings: a 1920x1080 frame, so a
      // quarter maps to column 480 and row 270, a half to 960 and 540.
      add_row('{make_item(1, 0, CLS_PERSON, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF),
                WANT_RECT, make_rect(0, CLS_PERSON, 16'hFFFF, 480, 270, 481, 271)});
      // Confidence one below the threshold, then exactly at it.
      add_row('{make_item(0, 0, CLS_PERSON, 13106, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, CLS_CHAIR, 13107, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF),
                WANT_RECT, make_rect(1, CLS_CHAIR, 13107, 480, 270, 481, 271)});
      // Untracked class, labels above twenty.
      add_row('{make_item(0, 0, 0, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, NUM_CLASSES, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, 255, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      // Zero-width box, top above the cut, bottom inside the margin.
      add_row('{make_item(0, 0, CLS_CAR, 16'hFFFF, Q_HALF, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, CLS_CAR, 16'hFFFF, Q_QUARTER, 0,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, CLS_CAR, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, 65535), WANT_NONE, '0});
      // Coordinate extremes clamp to the frame edges.
      add_row('{make_item(0, 0, CLS_CAR, 16'hFFFF, Q_MIN, Q_QUARTER,
                          Q_MAX, Q_HALF),
                WANT_RECT, make_rect(2, CLS_CAR, 16'hFFFF, 0, 270, 1920, 271)});
      add_row('{make_item(0, 0, CLS_PERSON, 0, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      // Negative coordinates truncate toward zero.
      add_row('{make_item(0, 0, CLS_PERSON, 40000, -1, 8000, 30000, 50000),
                WANT_MODEL, '0});
      add_row('{make_item(0, 0, CLS_CHAIR, 20000, 12000, 20000, 60000, 60000),
                WANT_MODEL, '0});
      // End marker, then a good proposal that must be ignored.
      add_row('{make_item(0, 1, CLS_PERSON, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, CLS_PERSON, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      // A new frame restarts the object ids.
      add_row('{make_item(1, 0, CLS_PERSON, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF),
                WANT_RECT, make_rect(0, CLS_PERSON, 16'hFFFF, 480, 270, 481, 271)});
      // Frame start together with an end marker closes the frame at once.
      add_row('{make_item(1, 1, CLS_PERSON, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      add_row('{make_item(0, 0, CLS_PERSON, 16'hFFFF, Q_QUARTER, Q_QUARTER,
                          Q_HALF, Q_HALF), WANT_NONE, '0});
      // Top exactly at the cut and bottom just clear of the margin.
      add_row('{make_item(1, 0, CLS_CAR, 16'hFFFF, Q_QUARTER, 6554,
                          Q_HALF, 64898), WANT_MODEL, '0});
      add_row('{make_item(0, 0, CLS_CAR, 16'hFFFF, Q_MAX, Q_MAX,
                          Q_MAX, Q_MAX), WANT_MODEL, '0});
      add_row('{make_item(0, 0, CLS_CAR, 16'hFFFF, Q_MIN, Q_MIN,
                          Q_MIN, Q_MIN), WANT_MODEL, '0});

      foreach (directed_rows[n]) begin
         send_proposal(directed_rows[n].item, directed_rows[n].check, directed_rows[n].want);
      end

      // Random phases: fixed extremes first, then random register sets.
      for (phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: settings = '{13'd4096, 13'd4096, 16'd0, 21'h1FFFFF, 13'd0, 13'd0};
            2: settings = '{13'd8191, 13'd8191, 16'hFFFF, 21'h1FFFFF, 13'd0, 13'd0};
            3: settings = '{13'd0, RST_FRAME_HEIGHT, RST_CONF_THRESH, RST_CLASS_MASK,
                            RST_TOP_CUT, RST_BOTTOM_MARGIN};
            4: settings = '{13'd1, 13'd1, 16'd0, 21'h1FFFFF, 13'd0, 13'd0};
            5: settings = '{13'd1920, 13'd500, 16'd0, 21'h1FFFFF, 13'd8191, 13'd8191};
            6: settings = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_CONF_THRESH, 21'd0,
                            RST_TOP_CUT, RST_BOTTOM_MARGIN};
            default: begin
               settings.frame_width          = 13'($urandom_range(16, 8191));
               settings.frame_height         = 13'($urandom_range(16, 8191));
               settings.confidence_threshold = 16'($urandom_range(0, 40000));
               settings.tracked_class_mask   = 21'($urandom);
               settings.top_cut_rows         = 13'($urandom_range(0, settings.frame_height / 4));
               settings.bottom_margin_rows   = 13'($urandom_range(0, settings.frame_height / 8));
            end
         endcase
         load_settings(settings);
         // Hold the receiver off while proposals keep coming, so the filter
         // fills up and stalls its input.
         if (phase == 7) hold_request = 1'b1;

         // A clean frame of more than the proposal budget opens the first
         // phase, so object ids run through their whole range.
         clean_frame = (phase == 1);
         target      = live_items + PHASE_ITEMS;
         while (live_items < target) begin
            frame_kind = $urandom_range(0, 19);
            if (frame_kind < 2 && !clean_frame) begin
               // Noise: every field random.
               it.frame_start = 1'($urandom);
               it.end_marker  = 1'($urandom);
               it.class_label = 8'($urandom);
               it.confidence  = 16'($urandom);
               it.left_norm   = 18'($urandom);
               it.top_norm    = 18'($urandom);
               it.right_norm  = 18'($urandom);
               it.bottom_norm = 18'($urandom);
               send_proposal(it, WANT_MODEL, '0);
            end else begin
               if (clean_frame) begin
                  frame_len = MAX_PROPOSALS + 4;
               end else if ($urandom_range(0, 9) == 0) begin
                  frame_len = $urandom_range(MAX_PROPOSALS - 3, MAX_PROPOSALS + 12);
               end else begin
                  frame_len = $urandom_range(1, 20);
               end
               // A frame kind of two leaves out the frame start.
               for (k = 0; k < frame_len; k++) begin
                  send_proposal(random_proposal(k == 0 && frame_kind != 2, clean_frame),
                                WANT_MODEL, '0);
               end
               if ($urandom_range(0, 9) != 0) begin
                  it             = random_proposal(1'b0, 1'b0);
                  it.end_marker  = 1'b1;
                  send_proposal(it, WANT_MODEL, '0);
               end
               repeat ($urandom_range(0, 2)) send_proposal(random_proposal(1'b0, 1'b0),
                                                           WANT_MODEL, '0);
               clean_frame = 1'b0;
            end
         end
      end

      // Drain and finish.
      proposal_chan.valid <= 1'b0;
      while (expected_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("detection_box_filter_tb OK");
      end else begin
         $display("detection_box_filter_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/dbf_pkg.sv
src/dbf_if.sv
src/dbf_csr.sv
src/dbf_scale.sv
src/dbf_eval.sv
src/detection_box_filter.sv
src/dbf_checker.sv
tb/sv/detection_box_filter_tb.sv
